/* sv/page_swap_slot_manager_defines.svh */
// assertion macros for the page swap slot manager
// used by the top level only, needs a clk and rst in scope
`ifndef PAGE_SWAP_SLOT_MANAGER_DEFINES_SVH
`define PAGE_SWAP_SLOT_MANAGER_DEFINES_SVH

// same-cycle implication
`define PSSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pssm_pkg.sv */
// types and constants of the page swap slot manager
// no dependencies; used by the interfaces and all modules
package pssm_pkg;

  // field widths
  localparam int PAGE_W  = 6;
  localparam int FRAME_W = 5;
  localparam int LOC_W   = 6;
  localparam int OUT_W   = 6;

  // table sizes, settled by the 6-bit page and location fields
  localparam int NUM_PAGES  = 64;
  localparam int SWAP_SLOTS = 64;
  localparam int SLOT_W     = $clog2(SWAP_SLOTS);

  // scan window: one group per cycle, split into sub-groups for encoding
  localparam int GROUP_W    = 16;
  localparam int SUB_W      = 4;
  localparam int NUM_GROUPS = NUM_PAGES / GROUP_W;
  localparam int NUM_SUBS   = GROUP_W / SUB_W;
  localparam int GRP_W      = $clog2(NUM_GROUPS);
  localparam int POS_W      = $clog2(GROUP_W);
  localparam int SUBPOS_W   = $clog2(SUB_W);
  localparam int SUBIDX_W   = $clog2(NUM_SUBS);
  localparam int K_W        = $clog2(NUM_GROUPS + 1);

  typedef enum logic [1:0] {
    OP_FIND     = 2'd0,
    OP_SWAP_OUT = 2'd1,
    OP_SWAP_IN  = 2'd2,
    OP_LOAD     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_VALID  = 2'd1,
    ST_SWAP_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [LOC_W-1:0]  location;
    logic [PAGE_W-1:0] vpage;
    logic              dirty;
  } row_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic rd_issue;
    logic exec;
    logic fail;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_t op;
    logic    scan_hit;
    logic    scan_last;
    logic    out_free;
  } stat_t;

endpackage

/* sv/pssm_if.sv */
// request and response channels of the page swap slot manager
// depends on pssm_pkg for field widths
interface pssm_req_if import pssm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [PAGE_W-1:0]  page_number;
  logic [FRAME_W-1:0] frame_number;
  logic               load_valid;

  modport source (output valid, opcode, page_number, frame_number, load_valid,
                  input ready);
  modport sink   (input valid, opcode, page_number, frame_number, load_valid,
                  output ready);
endinterface

interface pssm_rsp_if import pssm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] victim_page;
  logic [OUT_W-1:0] swap_slot;
  logic [1:0]       status;

  modport source (output valid, victim_page, swap_slot, status, input ready);
  modport sink   (input valid, victim_page, swap_slot, status, output ready);
endinterface

/* sv/pssm_ctrl.sv */
// controller state machine of the page swap slot manager
// depends on pssm_pkg for the command and status structs
module pssm_ctrl import pssm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_op,
  output logic       req_ready,
  input  stat_t      stat,
  output cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_READ = 5'b00100,
    S_EXEC = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencing per opcode
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          case (opcode_t'(req_op))
            OP_LOAD:    state_next = S_EXEC;
            OP_SWAP_IN: state_next = S_READ;
            default:    state_next = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_hit) begin
          state_next = S_READ;
        end else if (stat.scan_last) begin
          cmd.fail   = 1'b1;
          state_next = S_RESP;
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* sv/pssm_datapath.sv */
// page table, slot bitmap, scan unit and result registers
// depends on pssm_pkg; driven by pssm_ctrl commands
module pssm_datapath import pssm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [1:0]         req_opcode,
  input  logic [PAGE_W-1:0]  req_page_number,
  input  logic [FRAME_W-1:0] req_frame_number,
  input  logic               req_load_valid,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [OUT_W-1:0]   rsp_victim_page,
  output logic [OUT_W-1:0]   rsp_swap_slot,
  output logic [1:0]         rsp_status
);

  // latched request
  opcode_t            op_q;
  logic [PAGE_W-1:0]  page_q;
  logic [FRAME_W-1:0] frame_q;
  logic               lvalid_q;

  // table state
  logic [NUM_PAGES-1:0]  entry_valid;
  logic [NUM_PAGES-1:0]  written;
  logic [SWAP_SLOTS-1:0] slot_used;
  logic [PAGE_W-1:0]     victim_pointer;
  row_t                  mem [NUM_PAGES];
  row_t                  rdata;
  logic                  written_q;
  row_t                  row_rd;
  row_t                  wrow;
  logic                  mem_we;
  logic [PAGE_W-1:0]     raddr;

  // scan unit
  logic [K_W-1:0]        scan_k;
  logic [PAGE_W-1:0]     found_idx;
  logic [NUM_PAGES-1:0]  scan_vec;
  logic [PAGE_W-1:0]     base;
  logic [GRP_W-1:0]      grp;
  logic [GROUP_W-1:0]    window;
  logic [GROUP_W-1:0]    mask;
  logic [GROUP_W-1:0]    masked;
  logic [NUM_SUBS-1:0]   sub_any;
  logic [SUBPOS_W-1:0]   sub_pos [NUM_SUBS];
  logic [SUBIDX_W-1:0]   sel_sub;
  logic                  hit;
  logic [PAGE_W-1:0]     hit_idx;

  // staged result
  logic [OUT_W-1:0] res_victim;
  logic [OUT_W-1:0] res_slot;
  status_t          res_status;

  // window over valid entries (round robin) or free slots (from zero)
  always_comb begin
    scan_vec = (op_q == OP_FIND) ? entry_valid : ~slot_used;
    base     = (op_q == OP_FIND) ? victim_pointer : '0;
    grp      = GRP_W'(base[PAGE_W-1 -: GRP_W] + scan_k[GRP_W-1:0]);
    window   = scan_vec[grp*GROUP_W +: GROUP_W];
  end

  // first group starts at the pointer, the wrap group ends below it
  always_comb begin
    for (int i = 0; i < GROUP_W; i++) begin
      if (scan_k == '0) begin
        mask[i] = (POS_W'(i) >= base[POS_W-1:0]);
      end else if (scan_k == K_W'(NUM_GROUPS)) begin
        mask[i] = (POS_W'(i) < base[POS_W-1:0]);
      end else begin
        mask[i] = 1'b1;
      end
    end
    masked = window & mask;
  end

  // two-level lowest-set-bit encoder
  always_comb begin
    for (int s = 0; s < NUM_SUBS; s++) begin
      sub_any[s] = |masked[s*SUB_W +: SUB_W];
      sub_pos[s] = '0;
      for (int j = SUB_W - 1; j >= 0; j--) begin
        if (masked[s*SUB_W + j]) sub_pos[s] = SUBPOS_W'(j);
      end
    end
    sel_sub = '0;
    for (int s = NUM_SUBS - 1; s >= 0; s--) begin
      if (sub_any[s]) sel_sub = SUBIDX_W'(s);
    end
    hit     = |sub_any;
    hit_idx = {grp, sel_sub, sub_pos[sel_sub]};
  end

  assign stat.op        = op_q;
  assign stat.scan_hit  = hit;
  assign stat.scan_last = (scan_k == K_W'(NUM_GROUPS));
  assign stat.out_free  = !rsp_valid || rsp_ready;

  // row read back, never-written entries read as zero
  assign row_rd = written_q ? rdata : '0;
  assign raddr  = (op_q == OP_FIND) ? found_idx : page_q;
  assign mem_we = cmd.exec && (op_q != OP_FIND);

  always_comb begin
    case (op_q)
      OP_SWAP_OUT: wrow = '{location: LOC_W'(found_idx), vpage: row_rd.vpage, dirty: 1'b1};
      OP_SWAP_IN:  wrow = '{location: LOC_W'(frame_q), vpage: page_q, dirty: 1'b1};
      OP_LOAD:     wrow = '{location: LOC_W'(frame_q), vpage: page_q, dirty: 1'b0};
      default:     wrow = row_rd;
    endcase
  end

  // page table memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[page_q] <= wrow;
    if (cmd.rd_issue) begin
      rdata     <= mem[raddr];
      written_q <= written[raddr];
    end
  end

  // control state: flags, bitmap, pointer, scan step, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid    <= '0;
      written        <= '0;
      slot_used      <= '0;
      victim_pointer <= '0;
      scan_k         <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      if (cmd.accept) scan_k <= '0;
      else if (cmd.scan_step) scan_k <= scan_k + 1'b1;
      if (cmd.exec) begin
        case (op_q)
          OP_FIND: victim_pointer <= found_idx;
          OP_SWAP_OUT: begin
            slot_used[found_idx[SLOT_W-1:0]] <= 1'b1;
            entry_valid[page_q]              <= 1'b0;
            written[page_q]                  <= 1'b1;
          end
          OP_SWAP_IN: begin
            slot_used[row_rd.location[SLOT_W-1:0]] <= 1'b0;
            entry_valid[page_q]                    <= 1'b1;
            written[page_q]                        <= 1'b1;
          end
          default: begin
            entry_valid[page_q] <= lvalid_q;
            written[page_q]     <= 1'b1;
          end
        endcase
      end
      if (cmd.load_out) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= opcode_t'(req_opcode);
      page_q   <= req_page_number;
      frame_q  <= req_frame_number;
      lvalid_q <= req_load_valid;
    end
    if (cmd.scan_step && hit) found_idx <= hit_idx;
    if (cmd.fail) begin
      res_victim <= '0;
      res_slot   <= '0;
      res_status <= (op_q == OP_FIND) ? ST_NO_VALID : ST_SWAP_FULL;
    end else if (cmd.exec) begin
      res_status <= ST_DONE;
      res_victim <= (op_q == OP_FIND) ? OUT_W'(row_rd.vpage) : '0;
      case (op_q)
        OP_SWAP_OUT: res_slot <= OUT_W'(found_idx);
        OP_SWAP_IN:  res_slot <= OUT_W'(row_rd.location);
        default:     res_slot <= '0;
      endcase
    end
    if (cmd.load_out) begin
      rsp_victim_page <= res_victim;
      rsp_swap_slot   <= res_slot;
      rsp_status      <= res_status;
    end
  end

endmodule

/* sv/page_swap_slot_manager.sv */
// page swap slot manager: one request at a time, result in an output register
// the scan unit covers 16 table entries per cycle; a miss runs through every group and the wrap group
// next request is taken the cycle after the result is registered
// reset clears valid, written and slot bits and the pointer
// (depends on pssm_pkg, pssm_if, pssm_ctrl, pssm_datapath)
`include "page_swap_slot_manager_defines.svh"

module page_swap_slot_manager import pssm_pkg::*; (
  input logic        clk,
  input logic        rst,
  pssm_req_if.sink   req,
  pssm_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t stat;
  logic  ready;

  assign req.ready = ready;

  // sequencer
  pssm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.opcode),
    .req_ready (ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // tables and scan unit
  pssm_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .req_opcode       (req.opcode),
    .req_page_number  (req.page_number),
    .req_frame_number (req.frame_number),
    .req_load_valid   (req.load_valid),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_victim_page  (rsp.victim_page),
    .rsp_swap_slot    (rsp.swap_slot),
    .rsp_status       (rsp.status)
  );

  // checks
  `PSSM_ASSERT_NEXT(a_one_in_flight, req.valid && ready, !ready, "request taken while busy")
  `PSSM_ASSERT_NOW(a_full_clean, rsp.valid && rsp.status == ST_SWAP_FULL,
    rsp.swap_slot == '0 && rsp.victim_page == '0, "swap full result carries data")
  `PSSM_ASSERT_NOW(a_miss_clean, rsp.valid && rsp.status == ST_NO_VALID,
    rsp.swap_slot == '0 && rsp.victim_page == '0, "victim miss result carries data")

endmodule

/* bench/pssm_result_checker.sv */
`timescale 1ns / 100ps
// response checker for the page swap slot manager bench: mirrors the page table,
// swap bitmap and victim pointer, and compares every response in order
// depends on pssm_pkg and the request and response interfaces of pssm_if
module pssm_result_checker import pssm_pkg::*; (
  input  logic clk,
  input  logic rst,
  pssm_req_if  req,
  pssm_rsp_if  rsp,
  output int   mismatches,
  output int   pending
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [OUT_W-1:0] victim_page;
    logic [OUT_W-1:0] swap_slot;
    status_t          status;
  } response_t;

  // mirrored page table, swap bitmap and victim pointer
  logic              page_ok    [NUM_PAGES];
  logic [LOC_W-1:0]  page_loc   [NUM_PAGES];
  logic [PAGE_W-1:0] page_vpn   [NUM_PAGES];
  logic              page_dirty [NUM_PAGES];
  logic              slot_taken [SWAP_SLOTS];
  logic [PAGE_W-1:0] scan_ptr;
  response_t         expected_q [$];

  // update the mirrored state for one request and return its response
  function automatic response_t apply_request(opcode_t op, logic [PAGE_W-1:0] page,
                                              logic [FRAME_W-1:0] frame, logic lv);
    response_t         r;
    logic              found;
    logic [PAGE_W-1:0] start;
    logic [PAGE_W-1:0] idx;
    logic [LOC_W-1:0]  s;
    r = '0;
    found = 1'b0;
    s = '0;
    start = scan_ptr;
    case (op)
      OP_FIND: begin
        // round-robin scan, pointer parks on the victim
        for (int k = 0; k < NUM_PAGES; k++) begin
          idx = start + PAGE_W'(k);
          if (!found && page_ok[idx]) begin
            found = 1'b1;
            scan_ptr = idx;
            r.victim_page = page_vpn[idx];
          end
        end
        if (!found) r.status = ST_NO_VALID;
      end
      OP_SWAP_OUT: begin
        // lowest free slot
        for (int k = SWAP_SLOTS - 1; k >= 0; k--) begin
          if (!slot_taken[k]) begin
            found = 1'b1;
            s = LOC_W'(k);
          end
        end
        if (!found) begin
          r.status = ST_SWAP_FULL;
        end else begin
          slot_taken[s] = 1'b1;
          page_ok[page] = 1'b0;
          page_loc[page] = s;
          page_dirty[page] = 1'b1;
          r.swap_slot = s;
        end
      end
      OP_SWAP_IN: begin
        // every 6-bit location is a legal slot, so it is always freed
        s = page_loc[page];
        slot_taken[s] = 1'b0;
        r.swap_slot = s;
        page_ok[page] = 1'b1;
        page_loc[page] = LOC_W'(frame);
        page_vpn[page] = page;
        page_dirty[page] = 1'b1;
      end
      default: begin
        page_ok[page] = lv;
        page_loc[page] = LOC_W'(frame);
        page_vpn[page] = page;
        page_dirty[page] = 1'b0;
      end
    endcase
    return r;
  endfunction

  // compare responses, then predict accepted requests
  always @(posedge clk) begin
    response_t got;
    response_t want;
    if (rst) begin
      for (int i = 0; i < NUM_PAGES; i++) begin
        page_ok[i] = 1'b0;
        page_loc[i] = '0;
        page_vpn[i] = '0;
        page_dirty[i] = 1'b0;
      end
      for (int i = 0; i < SWAP_SLOTS; i++) slot_taken[i] = 1'b0;
      scan_ptr = '0;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = {rsp.victim_page, rsp.swap_slot, status_t'(rsp.status)};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected response: victim %0d slot %0d status %0d",
                     got.victim_page, got.swap_slot, got.status);
        end else begin
          want = expected_q.pop_front();
          if (got.victim_page !== want.victim_page || got.swap_slot !== want.swap_slot ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("response mismatch: expected victim %0d slot %0d status %0d, got victim %0d slot %0d status %0d",
                       want.victim_page, want.swap_slot, want.status,
                       got.victim_page, got.swap_slot, got.status);
          end
        end
      end
      if (req.valid && req.ready)
        expected_q.push_back(apply_request(opcode_t'(req.opcode), req.page_number,
                                           req.frame_number, req.load_valid));
    end
    pending = expected_q.size();
  end

endmodule

/* bench/page_swap_slot_manager_test.sv */
`timescale 1ns / 100ps
// top of the page swap slot manager bench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict
// depends on pssm_pkg, pssm_if, the block and pssm_result_checker
module page_swap_slot_manager_test;
  import pssm_pkg::*;

  localparam int RSP_HOLD_CYCLES = 150;
  localparam int IDLE_LIMIT      = 5000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int PHASE_ITEMS     = 450;
  localparam int HOT_COUNT       = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int hold_asked = 0;
  int sent = 0;
  int idle_cycles = 0;
  int check_errors;
  int results_pending;
  logic [PAGE_W-1:0] hot_pages [HOT_COUNT];

  pssm_req_if req_ch();
  pssm_rsp_if rsp_ch();

  page_swap_slot_manager dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  pssm_result_checker result_check (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .mismatches(check_errors),
    .pending(results_pending)
  );

  always #1 clk = ~clk;

  // offer one request at a falling edge, return at the falling edge after acceptance
  task automatic issue_request(opcode_t op, logic [PAGE_W-1:0] page,
                               logic [FRAME_W-1:0] frame, logic lv);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.page_number <= page;
    req_ch.frame_number <= frame;
    req_ch.load_valid <= lv;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  // stop offering until every outstanding response has come back
  task automatic drain_pause();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
  endtask

  // mostly pages from a small working set so entries get reused
  function automatic logic [PAGE_W-1:0] pick_page();
    if ($urandom_range(9) < 7) return hot_pages[$urandom_range(HOT_COUNT - 1)];
    return PAGE_W'($urandom_range(NUM_PAGES - 1));
  endfunction

  // random traffic: fault sequences, loads, swap-out bursts and noise
  task automatic random_mix(int upto);
    int choice;
    int burst;
    while (sent < upto) begin
      choice = $urandom_range(99);
      if (choice < 40) begin
        // page fault: pick victim, evict, bring a page in
        issue_request(OP_FIND, pick_page(), FRAME_W'($urandom), 1'($urandom));
        issue_request(OP_SWAP_OUT, pick_page(), FRAME_W'($urandom), 1'($urandom));
        issue_request(OP_SWAP_IN, pick_page(), FRAME_W'($urandom), 1'($urandom));
      end else if (choice < 65) begin
        issue_request(OP_LOAD, pick_page(), FRAME_W'($urandom), $urandom_range(3) != 0);
      end else if (choice < 69) begin
        // swap-out burst, may run the swap space full
        burst = $urandom_range(20, 72);
        repeat (burst) issue_request(OP_SWAP_OUT, pick_page(), FRAME_W'($urandom), 1'($urandom));
        repeat (burst / 2) issue_request(OP_SWAP_IN, pick_page(), FRAME_W'($urandom), 1'($urandom));
      end else begin
        issue_request(opcode_t'($urandom_range(3)), PAGE_W'($urandom), FRAME_W'($urandom),
                      1'($urandom));
      end
    end
  endtask

  // response side back-pressure, with long holds on demand
  initial begin
    int served;
    served = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked != served) begin
        served++;
        rsp_ch.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(negedge clk);
      end
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("page_swap_slot_manager test failed");
      $finish;
    end
  end

  // request stimulus and verdict
  initial begin
    req_ch.valid <= 1'b0;
    req_ch.opcode <= OP_FIND;
    req_ch.page_number <= '0;
    req_ch.frame_number <= '0;
    req_ch.load_valid <= 1'b0;
    for (int i = 0; i < HOT_COUNT; i++) hot_pages[i] = PAGE_W'($urandom);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, untouched entry, extremes, pointer wrap
    issue_request(OP_FIND, 6'd0, 5'd0, 1'b0);
    issue_request(OP_SWAP_IN, 6'd5, 5'd31, 1'b1);
    issue_request(OP_LOAD, 6'd0, 5'd31, 1'b1);
    issue_request(OP_LOAD, 6'd63, 5'd0, 1'b1);
    issue_request(OP_LOAD, 6'd42, 5'd21, 1'b0);
    issue_request(OP_LOAD, 6'd21, 5'd10, 1'b1);
    issue_request(OP_FIND, 6'd63, 5'd31, 1'b1);
    issue_request(OP_SWAP_OUT, 6'd0, 5'd7, 1'b0);
    issue_request(OP_FIND, 6'd0, 5'd0, 1'b0);
    issue_request(OP_SWAP_OUT, 6'd5, 5'd0, 1'b1);
    issue_request(OP_SWAP_OUT, 6'd63, 5'd31, 1'b0);
    issue_request(OP_FIND, 6'd1, 5'd2, 1'b0);
    issue_request(OP_SWAP_IN, 6'd0, 5'd17, 1'b0);
    issue_request(OP_SWAP_OUT, 6'd21, 5'd3, 1'b1);
    issue_request(OP_FIND, 6'd0, 5'd0, 1'b0);
    issue_request(OP_LOAD, 6'd0, 5'd3, 1'b0);
    issue_request(OP_FIND, 6'd0, 5'd0, 1'b0);
    issue_request(OP_SWAP_IN, 6'd63, 5'd31, 1'b1);
    issue_request(OP_FIND, 6'd0, 5'd0, 1'b0);

    // run the swap space full, then release part of it
    repeat (70) issue_request(OP_SWAP_OUT, pick_page(), FRAME_W'($urandom), 1'($urandom));
    for (int i = 0; i < HOT_COUNT; i++)
      issue_request(OP_SWAP_IN, hot_pages[i], FRAME_W'($urandom), 1'($urandom));

    // random phases with different idle and stall rates
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0;
          rsp_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 59;
          rsp_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          rsp_stall_pct = 59;
        end
        default: begin
          send_idle_pct = 26;
          rsp_stall_pct = 26;
        end
      endcase
      for (int i = 0; i < HOT_COUNT; i++) hot_pages[i] = PAGE_W'($urandom);
      random_mix(sent + PHASE_ITEMS / 2);
      // long response hold while requests keep coming in the first phase, a drain pause in the second
      if (p == 0) hold_asked++;
      if (p == 1) drain_pause();
      random_mix(sent + PHASE_ITEMS / 2);
    end

    // wait for the last responses, then give the verdict
    drain_pause();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (check_errors == 0)
      $display("page_swap_slot_manager test passed");
    else
      $display("page_swap_slot_manager test failed");
    $finish;
  end

endmodule
